@@ hdl/lbut_pkg.sv @@
// ----------------------------------------------------------------------------
// lbut_pkg
// Shared types, constants and the Windows-1252 upper-range table for the
// legacy byte to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package lbut_pkg;

    // source_mode codes (code 3 behaves as ISO-8859-1)
    localparam logic [1:0] MODE_UTF8   = 2'd0;
    localparam logic [1:0] MODE_LATIN1 = 2'd1;
    localparam logic [1:0] MODE_CP1252 = 2'd2;

    // register indexes on the config port
    localparam logic REG_SOURCE_MODE  = 1'b0;
    localparam logic REG_OUT_CAPACITY = 1'b1;

    // byte classes and UTF-8 framing
    localparam logic [7:0]  ASCII_LIMIT    = 8'h80;
    localparam logic [7:0]  CP1252_HI_END  = 8'hA0;
    localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
    localparam logic [7:0]  LEAD2_MARK     = 8'hC0;
    localparam logic [7:0]  LEAD3_MARK     = 8'hE0;
    localparam logic [7:0]  CONT_MARK      = 8'h80;

    // sequence lengths
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // one encoded sequence: bytes in emit order, length, total after first byte
    typedef struct packed {
        logic [2:0][7:0] seq_bytes;
        logic [1:0]      seq_len;
        logic [15:0]     base_total;
    } lbut_entry_t;

    // queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } lbut_qstat_t;

    // code points for bytes 0x80..0x9F
    function automatic logic [15:0] cp1252_upper(input logic [4:0] idx);
        logic [15:0] cp;
        case (idx)
            5'd0:    cp = 16'h20AC;
            5'd1:    cp = 16'h0081;
            5'd2:    cp = 16'h201A;
            5'd3:    cp = 16'h0192;
            5'd4:    cp = 16'h201E;
            5'd5:    cp = 16'h2026;
            5'd6:    cp = 16'h2020;
            5'd7:    cp = 16'h2021;
            5'd8:    cp = 16'h02C6;
            5'd9:    cp = 16'h2030;
            5'd10:   cp = 16'h0160;
            5'd11:   cp = 16'h2039;
            5'd12:   cp = 16'h0152;
            5'd13:   cp = 16'h008D;
            5'd14:   cp = 16'h017D;
            5'd15:   cp = 16'h008F;
            5'd16:   cp = 16'h0090;
            5'd17:   cp = 16'h2018;
            5'd18:   cp = 16'h2019;
            5'd19:   cp = 16'h201C;
            5'd20:   cp = 16'h201D;
            5'd21:   cp = 16'h2022;
            5'd22:   cp = 16'h2013;
            5'd23:   cp = 16'h2014;
            5'd24:   cp = 16'h02DC;
            5'd25:   cp = 16'h2122;
            5'd26:   cp = 16'h0161;
            5'd27:   cp = 16'h203A;
            5'd28:   cp = 16'h0153;
            5'd29:   cp = 16'h009D;
            5'd30:   cp = 16'h017E;
            5'd31:   cp = 16'h0178;
            default: cp = 16'h0000;
        endcase
        return cp;
    endfunction

endpackage

@@ hdl/lbut_queue.sv @@
// ----------------------------------------------------------------------------
// lbut_queue
// Small FIFO of encoded sequences between the front and the back.
// ----------------------------------------------------------------------------
module lbut_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  lbut_pkg::lbut_entry_t push_entry,
    input  logic                 pop,
    output lbut_pkg::lbut_entry_t head_entry,
    output lbut_pkg::lbut_qstat_t qstat
);
    import lbut_pkg::*;

    lbut_entry_t       slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   fill_reg, fill_next;

    // status and head
    assign qstat.full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign qstat.empty = (fill_reg == '0);
    assign head_entry  = slots[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ hdl/lbut_front.sv @@
// ----------------------------------------------------------------------------
// lbut_front
// Accepts source bytes, maps them to code points, checks the fit against
// the capacity, keeps the running count and queues the encoded sequence.
// ----------------------------------------------------------------------------
module lbut_front #(
    parameter int SEQ_RESERVE = 4,
    parameter int COUNT_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            source_mode,
    input  logic [15:0]           out_capacity,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    input  lbut_pkg::lbut_qstat_t qstat,
    output logic                  push,
    output lbut_pkg::lbut_entry_t push_entry,
    output logic [COUNT_BITS-1:0] count_value
);
    import lbut_pkg::*;

    localparam int CMP_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [CMP_W-1:0]      count_ext, cap_ext, lim_ext, cap_eff, reserve_ext;
    logic                  single, use_table, fits, accept;
    logic [15:0]           cp;
    logic [1:0]            seq_len;

    // effective capacity: never beyond what the count can hold
    assign count_ext   = CMP_W'(count_reg);
    assign cap_ext     = CMP_W'(out_capacity);
    assign lim_ext     = CMP_W'({COUNT_BITS{1'b1}});
    assign cap_eff     = (cap_ext < lim_ext) ? cap_ext : lim_ext;
    assign reserve_ext = CMP_W'(SEQ_RESERVE);

    // classify the byte
    assign single    = (source_mode == MODE_UTF8) || (in_byte < ASCII_LIMIT);
    assign use_table = (source_mode == MODE_CP1252) && (in_byte < CP1252_HI_END);
    assign cp        = use_table ? cp1252_upper(in_byte[4:0]) : {8'h00, in_byte};

    // fit check: a multi-byte sequence needs the full reserve
    assign fits = single ? (count_ext < cap_eff)
                         : ((count_ext + reserve_ext) <= cap_eff);

    // encode
    always_comb
    begin
        push_entry.seq_bytes = '0;
        if (single)
        begin
            seq_len                 = LEN_ONE;
            push_entry.seq_bytes[0] = in_byte;
        end
        else if (cp < TWO_BYTE_LIMIT)
        begin
            seq_len                 = LEN_TWO;
            push_entry.seq_bytes[0] = LEAD2_MARK | {3'b000, cp[10:6]};
            push_entry.seq_bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
        end
        else
        begin
            seq_len                 = LEN_THREE;
            push_entry.seq_bytes[0] = LEAD3_MARK | {4'h0, cp[15:12]};
            push_entry.seq_bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            push_entry.seq_bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
        end
        push_entry.seq_len    = seq_len;
        push_entry.base_total = 16'(count_ext + CMP_W'(1));
    end

    // handshake: take a beat whenever the queue has room
    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && fits;

    // running count, cleared after the last byte of a buffer
    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (in_last)
            begin
                count_next = '0;
            end
            else if (fits)
            begin
                count_next = count_reg + COUNT_BITS'(seq_len);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count_value = count_reg;

endmodule

@@ hdl/lbut_back.sv @@
// ----------------------------------------------------------------------------
// lbut_back
// Walks the head sequence of the queue and emits one UTF-8 byte per beat
// through an output register.
// ----------------------------------------------------------------------------
module lbut_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lbut_pkg::lbut_entry_t head_entry,
    input  lbut_pkg::lbut_qstat_t qstat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_byte,
    output logic                  out_last,
    output logic [15:0]           out_total
);
    import lbut_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic [15:0] total_reg, total_next;
    logic        load, take, is_last;

    // output register free or draining this cycle
    assign load    = !valid_reg || out_ready;
    assign take    = load && !qstat.empty;
    assign is_last = (idx_reg == (head_entry.seq_len - 2'd1));
    assign pop     = take && is_last;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        total_next = total_reg;
        if (take)
        begin
            valid_next = 1'b1;
            byte_next  = head_entry.seq_bytes[idx_reg];
            last_next  = is_last;
            total_next = head_entry.base_total + 16'(idx_reg);
            idx_next   = is_last ? 2'd0 : (idx_reg + 2'd1);
        end
        else if (load)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        total_reg <= total_next;
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;
    assign out_total = total_reg;

endmodule

@@ hdl/legacy_byte_to_utf8_transcoder_top.sv @@
// ----------------------------------------------------------------------------
// legacy_byte_to_utf8_transcoder_top
// Converts a stream of UTF-8, ISO-8859-1 or Windows-1252 bytes to UTF-8.
// ----------------------------------------------------------------------------
// Each input beat carries one source byte (tlast marks the end of a buffer)
// and yields one, two or three UTF-8 output beats, or none when the byte
// does not fit in out_capacity. The output emits one byte per cycle while
// m_tready is high; input beats are taken every cycle while the four-entry
// queue between the classifier and the emitter has room. An input beat
// passes through the queue and the output register before it shows on the
// output. Registers: source_mode at 0x0, out_capacity at 0x4. Each output
// beat carries the running byte count of the buffer, which restarts after
// the byte marked tlast.
module legacy_byte_to_utf8_transcoder_top #(
    parameter int SEQ_RESERVE = 4,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_buffer
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] total_written
    output logic        m_tlast    // last_of_run
);
    import lbut_pkg::*;

    logic [1:0]            source_mode_reg;
    logic [15:0]           out_capacity_reg;
    logic                  cfg_wr;
    lbut_qstat_t           qstat;
    lbut_entry_t           push_entry, head_entry;
    logic                  push, pop;
    logic [COUNT_BITS-1:0] count_value;
    logic [7:0]            out_byte;
    logic [15:0]           out_total;

    // config registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_mode_reg  <= MODE_UTF8;
            out_capacity_reg <= 16'hFFFF;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_SOURCE_MODE:  source_mode_reg  <= pwdata[1:0];
                REG_OUT_CAPACITY: out_capacity_reg <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_SOURCE_MODE:  prdata = {30'd0, source_mode_reg};
            REG_OUT_CAPACITY: prdata = {16'd0, out_capacity_reg};
            default:          prdata = '0;
        endcase
    end

    // classifier and count keeper
    lbut_front #(
        .SEQ_RESERVE (SEQ_RESERVE),
        .COUNT_BITS  (COUNT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .source_mode  (source_mode_reg),
        .out_capacity (out_capacity_reg),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .qstat        (qstat),
        .push         (push),
        .push_entry   (push_entry),
        .count_value  (count_value)
    );

    // sequence queue
    lbut_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .qstat      (qstat)
    );

    // byte emitter
    lbut_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (out_byte),
        .out_last   (m_tlast),
        .out_total  (out_total)
    );

    assign m_tdata = {out_total, out_byte};

    // checks
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> qstat.full)
        else $error("input stalled with room in the queue");

    a_count_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (count_value == '0))
        else $error("count not cleared after end of buffer");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[23:8] == $past(m_tdata[23:8]) + 16'd1)))
        else $error("multi-byte run broken or total not incremented");

    a_non_last_is_high: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> m_tdata[7])
        else $error("non-final byte of a run is not a lead or continuation byte");

endmodule

@@ dv/utf8_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_checker
// Watches the config port and both streams of the transcoder, predicts the
// UTF-8 beats for every accepted source byte and compares them in order.
// ----------------------------------------------------------------------------
module utf8_stream_checker #(
    parameter int SEQ_RESERVE = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // input stream
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_buffer
    // output stream
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] total_written
    input  logic        m_tlast,   // last_of_run
    // status toward the testbench top
    output int          fail_count,
    output int          pending_beats,
    output int          checked_beats
);
    import lbut_pkg::*;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_of_run;
        logic [15:0] total_written;
    } utf8_beat_t;

    // code points of bytes 0x80..0x9F in Windows-1252
    localparam logic [15:0] WIN1252_CP [32] = '{
        16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
        16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
    };

    logic [1:0]  mode_q;
    logic [15:0] cap_q;
    logic [15:0] fill_q;
    utf8_beat_t  utf8_expected_q[$];
    int          fails;
    int          checked;

    initial
    begin
        fails   = 0;
        checked = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        fails++;
    endtask

    // one predicted beat; the running total includes this byte
    task automatic add_beat(input logic [7:0] b, input logic last);
        utf8_beat_t beat;
        fill_q             = fill_q + 16'd1;
        beat.out_byte      = b;
        beat.last_of_run   = last;
        beat.total_written = fill_q;
        utf8_expected_q.push_back(beat);
    endtask

    // expected beats for one source byte, with the capacity rule applied
    task automatic encode_byte(input logic [7:0] b, input logic eob);
        logic [15:0] cp;
        cp = {8'h00, b};
        if (mode_q == MODE_UTF8 || b < ASCII_LIMIT)
        begin
            if (fill_q < cap_q)
                add_beat(b, 1'b1);
        end
        else
        begin
            if (mode_q == MODE_CP1252 && b < CP1252_HI_END)
                cp = WIN1252_CP[b[4:0]];
            // the whole sequence goes only when the reserve fits
            if ({1'b0, fill_q} + SEQ_RESERVE <= {1'b0, cap_q})
            begin
                if (cp < TWO_BYTE_LIMIT)
                begin
                    add_beat(LEAD2_MARK | {3'b000, cp[10:6]}, 1'b0);
                    add_beat(CONT_MARK | {2'b00, cp[5:0]}, 1'b1);
                end
                else
                begin
                    add_beat(LEAD3_MARK | {4'b0000, cp[15:12]}, 1'b0);
                    add_beat(CONT_MARK | {2'b00, cp[11:6]}, 1'b0);
                    add_beat(CONT_MARK | {2'b00, cp[5:0]}, 1'b1);
                end
            end
        end
        if (eob)
            fill_q = '0;
    endtask

    // compare an output beat with the oldest prediction
    task automatic check_beat();
        utf8_beat_t want;
        if (utf8_expected_q.size() == 0)
            report_mismatch("beat with nothing expected", m_tdata, 0);
        else
        begin
            want = utf8_expected_q.pop_front();
            checked++;
            if (m_tdata[7:0] != want.out_byte)
                report_mismatch("out_byte", m_tdata[7:0], want.out_byte);
            if (m_tlast != want.last_of_run)
                report_mismatch("last_of_run", m_tlast, want.last_of_run);
            if (m_tdata[23:8] != want.total_written)
                report_mismatch("total_written", m_tdata[23:8], want.total_written);
        end
    endtask

    // register shadow, prediction and comparison
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_q = MODE_UTF8;
            cap_q  = 16'hFFFF;
            fill_q = '0;
            utf8_expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_SOURCE_MODE)
                    mode_q = pwdata[1:0];
                else
                    cap_q = pwdata[15:0];
            end
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_beat();
        end
        pending_beats <= utf8_expected_q.size();
        fail_count    <= fails;
        checked_beats <= checked;
    end

endmodule

@@ dv/legacy_byte_to_utf8_transcoder_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legacy_byte_to_utf8_transcoder_top_tb
// Drives source bytes and register settings into the transcoder with random
// gaps and output stalls; the checker beside the block judges every beat.
// ----------------------------------------------------------------------------
module legacy_byte_to_utf8_transcoder_top_tb;
    import lbut_pkg::*;

    localparam int          CLK_HALF       = 6;
    localparam int          RESET_CYCLES   = 6;
    localparam int          DRAIN_CYCLES   = 12;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_ITEMS    = 24;
    localparam logic [1:0]  MODE_SPARE     = 2'd3;   // unused code, acts as Latin-1

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    int          fail_count;
    int          pending_beats;
    int          checked_beats;
    int          items_sent  = 0;
    int          settings    = 0;
    int          ready_left  = 0;
    int          idle_cycles = 0;
    logic        stall_en    = 1'b1;
    bit          quiet       = 1'b0;

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    legacy_byte_to_utf8_transcoder_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    utf8_stream_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_beats (pending_beats),
        .checked_beats (checked_beats)
    );

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // output backpressure: runs of ready broken by stalls
    always @(posedge clk)
    begin
        if (ready_left > 0)
            ready_left <= ready_left - 1;
        else if (!stall_en || $urandom_range(0, 2) != 0)
        begin
            m_tready   <= 1'b1;
            ready_left <= $urandom_range(0, 10);
        end
        else
        begin
            m_tready   <= 1'b0;
            ready_left <= pick_gap();
        end
    end

    // watchdog on cycles with no beat and no register write
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // setup and access phases, then psel drops so that back-to-back writes stay apart
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // one source byte; waits for the beat to be taken
    task automatic send_beat(input logic [7:0] b, input logic eob);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // block idle: every predicted beat out, then room for dropped bytes
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_beats != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic [15:0] cap);
        wait_idle();
        write_reg(REG_SOURCE_MODE, {30'd0, mode});
        write_reg(REG_OUT_CAPACITY, {16'd0, cap});
        settings++;
    endtask

    // source byte weighted over ASCII, the C1 range and the upper half
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'($urandom_range(8'h00, 8'h7F));
        else if (r < 7)
            return 8'($urandom_range(8'h80, 8'h9F));
        else
            return 8'($urandom_range(8'hA0, 8'hFF));
    endfunction

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(0, 5))
            0:       return 16'hFFFF;
            1:       return 16'($urandom_range(0, 6));
            2:       return 16'($urandom_range(7, 40));
            3:       return 16'($urandom_range(0, 65535));
            4:       return 16'hFFFE;
            default: return 16'($urandom_range(3, 5));
        endcase
    endfunction

    // stimulus
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: passthrough, full capacity
        send_beat(8'h00, 1'b0);
        send_beat(8'h7F, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hFF, 1'b1);

        // Latin-1: two-byte forms at both ends of the upper half
        configure(MODE_LATIN1, 16'hFFFF);
        send_beat(8'h41, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'hA0, 1'b0);
        send_beat(8'hFF, 1'b1);

        // Windows-1252: table hits of three and two bytes, then plain bytes
        configure(MODE_CP1252, 16'hFFFF);
        send_beat(8'h80, 1'b0);
        send_beat(8'h81, 1'b0);
        send_beat(8'h9F, 1'b0);
        send_beat(8'h99, 1'b0);
        send_beat(8'hA0, 1'b0);
        send_beat(8'h7F, 1'b1);

        // tight capacity: a reserve refusal, ASCII filling the last slot,
        // a dropped byte ending the buffer, then a fresh buffer
        configure(MODE_CP1252, 16'd5);
        send_beat(8'h41, 1'b0);
        send_beat(8'hE9, 1'b0);
        send_beat(8'h41, 1'b0);
        send_beat(8'hE9, 1'b0);
        send_beat(8'h41, 1'b0);
        send_beat(8'h41, 1'b1);
        send_beat(8'hE9, 1'b0);

        // zero capacity with the spare mode code: nothing fits
        configure(MODE_SPARE, 16'd0);
        send_beat(8'h41, 1'b0);
        send_beat(8'hC4, 1'b1);

        // passthrough with room for one byte
        configure(MODE_UTF8, 16'd1);
        send_beat(8'h80, 1'b0);
        send_beat(8'hFF, 1'b1);

        // random phases
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            configure(2'($urandom_range(0, 3)), pick_capacity());
            quiet = ($urandom_range(0, 3) == 0);
            stall_en <= !quiet;
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_beat(pick_byte(), $urandom_range(0, 7) == 0);
        end

        wait_idle();
        $display("Summary: %0d source bytes sent over %0d register settings",
                 items_sent, settings);
        $display("Summary: %0d UTF-8 beats compared, %0d mismatches",
                 checked_beats, fail_count);
        if (fail_count == 0 && pending_beats == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/lbut_pkg.sv
hdl/lbut_queue.sv
hdl/lbut_front.sv
hdl/lbut_back.sv
hdl/legacy_byte_to_utf8_transcoder_top.sv
dv/utf8_stream_checker.sv
dv/legacy_byte_to_utf8_transcoder_top_tb.sv
